>>> sv/sror_pkg.sv
// Package: constants, types and helpers for the sequence reorder gap requester.
package sror_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int SEQ_W   = 16;
    localparam int TAG_W   = 32;
    localparam int LEN_W   = 8;
    localparam int KIND_W  = 2;
    localparam int LEFT_W  = 17;
    localparam int MASK_W  = 8;
    localparam int RETRY_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GAP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SNAP    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_RETRY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_WAIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd5;

    localparam logic [SEQ_W-1:0]   RST_START_SEQ   = 16'd0;
    localparam logic [SEQ_W-1:0]   RST_GAP_DELAY   = 16'd50;
    localparam logic [MASK_W-1:0]  RST_JITTER_MASK = 8'd15;
    localparam logic [SEQ_W-1:0]   RST_GAP_RETRY   = 16'd100;
    localparam logic [SEQ_W-1:0]   RST_SNAP_WAIT   = 16'd500;
    localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT = 4'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic             is_tick;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_out;
        logic [SEQ_W-1:0]  to_seq;
        logic [TAG_W-1:0]  out_tag;
        logic [LEN_W-1:0]  out_len;
        logic              last;
    } result_t;

    function automatic logic behind(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

    function automatic logic ahead(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        return (a != b) && !behind(a, b);
    endfunction

endpackage

>>> sv/sror_item_if.sv
// Interface: packet/tick request channel.
interface sror_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] seq;
    logic [31:0] pkt_tag;
    logic [7:0]  pkt_len;

    modport source (output valid, output opcode, output seq, output pkt_tag, output pkt_len,
                    input ready);
    modport sink   (input valid, input opcode, input seq, input pkt_tag, input pkt_len,
                    output ready);
endinterface

>>> sv/sror_result_if.sv
// Interface: result request channel.
interface sror_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] seq_out;
    logic [15:0] to_seq;
    logic [31:0] out_tag;
    logic [7:0]  out_len;
    logic        last;

    modport source (output valid, output kind, output seq_out, output to_seq, output out_tag,
                    output out_len, output last, input ready);
    modport sink   (input valid, input kind, input seq_out, input to_seq, input out_tag,
                    input out_len, input last, output ready);
endinterface

>>> sv/sror_front.sv
// Front end: accepts requests, tags ticks vs packets, two-entry queue to the back end.
module sror_front
(
    input  logic              clk,
    input  logic              rst_n,
    sror_item_if.sink         item,
    output logic              q_valid,
    output sror_pkg::item_t   q_item,
    input  logic              q_pop
);

    sror_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    sror_pkg::item_t in_item;

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.is_tick = item.opcode;
        in_item.seq     = item.seq;
        in_item.tag     = item.pkt_tag;
        in_item.len     = item.pkt_len;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

>>> sv/sror_back.sv
// Back end: reorder slots, drain sequencer, gap timer and result register.
module sror_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  sror_pkg::item_t                       q_item,
    output logic                                  q_pop,
    sror_result_if.source                         result,
    input  logic                                  cfg_we,
    input  logic [sror_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [sror_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DELIV = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_ARM   = 4'd3;
    localparam logic [3:0] S_SCANF = 4'd4;
    localparam logic [3:0] S_SCANM = 4'd5;
    localparam logic [3:0] S_GAP   = 4'd6;
    localparam logic [3:0] S_SNAP  = 4'd7;

    localparam int SW = sror_pkg::SEQ_W;
    localparam int NW = sror_pkg::SLOT_W;
    localparam int CW = sror_pkg::CNT_W;
    localparam logic [CW-1:0] SCAN_END = CW'(sror_pkg::SLOTS);

    // configuration
    logic [SW-1:0]                     gap_delay_reg;
    logic [sror_pkg::MASK_W-1:0]       jitter_mask_reg;
    logic [SW-1:0]                     gap_retry_reg;
    logic [SW-1:0]                     snap_wait_reg;
    logic [sror_pkg::RETRY_W-1:0]      retry_limit_reg;

    // slots
    logic                              slot_used_reg [sror_pkg::SLOTS];
    logic [SW-1:0]                     slot_seq_reg  [sror_pkg::SLOTS];
    logic [sror_pkg::TAG_W-1:0]        slot_tag_reg  [sror_pkg::SLOTS];
    logic [sror_pkg::LEN_W-1:0]        slot_len_reg  [sror_pkg::SLOTS];

    logic [3:0]                        state_reg, state_next;
    logic [SW-1:0]                     exp_reg, exp_next;
    logic                              armed_reg, armed_next;
    logic [sror_pkg::LEFT_W-1:0]       left_reg, left_next;
    logic [sror_pkg::RETRY_W-1:0]      retry_reg, retry_next;
    logic [15:0]                       lfsr_reg, lfsr_next;
    sror_pkg::item_t                   cur_reg, cur_next;
    logic [NW-1:0]                     idx_reg, idx_next;
    logic [CW-1:0]                     scan_reg, scan_next;
    logic [SW-1:0]                     far_seq_reg, far_seq_next;
    logic [SW-1:0]                     mn_reg, mn_next;
    logic                              have_reg, have_next;
    logic                              out_valid_reg, out_valid_next;
    sror_pkg::result_t                 out_data_reg;

    logic                              out_free;
    logic                              emit;
    sror_pkg::result_t                 emit_data;
    logic                              slot_wr_en;
    logic [NW-1:0]                     slot_wr_idx;
    logic [SW-1:0]                     slot_wr_seq;
    logic [sror_pkg::TAG_W-1:0]        slot_wr_tag;
    logic [sror_pkg::LEN_W-1:0]        slot_wr_len;
    logic                              slot_clr_en;

    logic                              dup_any;
    logic                              free_any;
    logic [NW-1:0]                     free_idx;
    logic                              hit_nxt;
    logic [NW-1:0]                     hit_idx;
    logic                              any_used;
    logic [SW-1:0]                     exp_inc;
    logic [NW-1:0]                     scan_idx;
    logic [15:0]                       lfsr_step;
    logic                              snap_cond;

    assign exp_inc   = exp_reg + 1'b1;
    assign scan_idx  = scan_reg[NW-1:0];
    assign out_free  = !out_valid_reg || result.ready;
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? sror_pkg::LFSR_TAPS : 16'h0000);
    assign snap_cond = (retry_reg >= retry_limit_reg);

    always_comb
    begin
        dup_any  = 1'b0;
        free_any = 1'b0;
        free_idx = '0;
        hit_nxt  = 1'b0;
        hit_idx  = '0;
        any_used = 1'b0;
        for (int i = sror_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (slot_used_reg[i] && (slot_seq_reg[i] == q_item.seq))
            begin
                dup_any = 1'b1;
            end
            if (!slot_used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = NW'(i);
            end
            if (slot_used_reg[i] && (slot_seq_reg[i] == exp_inc))
            begin
                hit_nxt = 1'b1;
                hit_idx = NW'(i);
            end
            if (slot_used_reg[i])
            begin
                any_used = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        armed_next   = armed_reg;
        left_next    = left_reg;
        retry_next   = retry_reg;
        lfsr_next    = lfsr_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        scan_next    = scan_reg;
        far_seq_next = far_seq_reg;
        mn_next      = mn_reg;
        have_next    = have_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        emit_data    = '0;
        slot_wr_en   = 1'b0;
        slot_wr_idx  = free_idx;
        slot_wr_seq  = q_item.seq;
        slot_wr_tag  = q_item.tag;
        slot_wr_len  = q_item.len;
        slot_clr_en  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.is_tick)
                    begin
                        if (armed_reg)
                        begin
                            if (left_reg > sror_pkg::LEFT_W'(1))
                            begin
                                left_next = left_reg - 1'b1;
                            end
                            else
                            begin
                                scan_next  = '0;
                                have_next  = 1'b0;
                                state_next = S_SCANM;
                            end
                        end
                    end
                    else if (!sror_pkg::behind(q_item.seq, exp_reg))
                    begin
                        if (q_item.seq == exp_reg)
                        begin
                            state_next = S_DELIV;
                        end
                        else if (dup_any)
                        begin
                            state_next = S_ARM;
                        end
                        else if (free_any)
                        begin
                            slot_wr_en = 1'b1;
                            state_next = S_ARM;
                        end
                        else
                        begin
                            idx_next     = '0;
                            far_seq_next = slot_seq_reg[0];
                            scan_next    = CW'(1);
                            state_next   = S_SCANF;
                        end
                    end
                end
            end
            S_DELIV, S_DRAIN:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_data.kind    = sror_pkg::KIND_DELIVER;
                    emit_data.seq_out = exp_reg;
                    emit_data.out_tag = (state_reg == S_DELIV) ? cur_reg.tag
                                                               : slot_tag_reg[idx_reg];
                    emit_data.out_len = (state_reg == S_DELIV) ? cur_reg.len
                                                               : slot_len_reg[idx_reg];
                    emit_data.last    = !hit_nxt;
                    slot_clr_en       = (state_reg == S_DRAIN);
                    exp_next          = exp_inc;
                    if (hit_nxt)
                    begin
                        idx_next   = hit_idx;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        armed_next = 1'b0;
                        state_next = S_ARM;
                    end
                end
            end
            S_ARM:
            begin
                if (!armed_reg && any_used)
                begin
                    lfsr_next  = lfsr_step;
                    left_next  = {1'b0, gap_delay_reg}
                               + sror_pkg::LEFT_W'(lfsr_step[7:0] & jitter_mask_reg);
                    armed_next = 1'b1;
                    retry_next = '0;
                end
                state_next = S_IDLE;
            end
            S_SCANF:
            begin
                if (scan_reg == SCAN_END)
                begin
                    if (sror_pkg::behind(cur_reg.seq, far_seq_reg))
                    begin
                        slot_wr_en  = 1'b1;
                        slot_wr_idx = idx_reg;
                        slot_wr_seq = cur_reg.seq;
                        slot_wr_tag = cur_reg.tag;
                        slot_wr_len = cur_reg.len;
                    end
                    state_next = S_ARM;
                end
                else
                begin
                    if (sror_pkg::ahead(slot_seq_reg[scan_idx], far_seq_reg))
                    begin
                        idx_next     = scan_idx;
                        far_seq_next = slot_seq_reg[scan_idx];
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_SCANM:
            begin
                if (scan_reg == SCAN_END)
                begin
                    if (!have_reg)
                    begin
                        armed_next = 1'b0;
                        left_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_GAP;
                    end
                end
                else
                begin
                    if (slot_used_reg[scan_idx] &&
                        (!have_reg || sror_pkg::behind(slot_seq_reg[scan_idx], mn_reg)))
                    begin
                        mn_next   = slot_seq_reg[scan_idx];
                        have_next = 1'b1;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_GAP:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_data.kind    = sror_pkg::KIND_GAP;
                    emit_data.seq_out = exp_reg;
                    emit_data.to_seq  = mn_reg - 1'b1;
                    emit_data.last    = !snap_cond;
                    if (snap_cond)
                    begin
                        retry_next = '0;
                        left_next  = {1'b0, snap_wait_reg};
                        state_next = S_SNAP;
                    end
                    else
                    begin
                        retry_next = retry_reg + 1'b1;
                        left_next  = {1'b0, gap_retry_reg};
                        state_next = S_IDLE;
                    end
                end
            end
            S_SNAP:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_data.kind = sror_pkg::KIND_SNAP;
                    emit_data.last = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we && (cfg_idx == sror_pkg::CFG_START_SEQ))
        begin
            exp_next = cfg_data;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.kind    = out_data_reg.kind;
    assign result.seq_out = out_data_reg.seq_out;
    assign result.to_seq  = out_data_reg.to_seq;
    assign result.out_tag = out_data_reg.out_tag;
    assign result.out_len = out_data_reg.out_len;
    assign result.last    = out_data_reg.last;

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        scan_reg    <= scan_next;
        far_seq_reg <= far_seq_next;
        mn_reg      <= mn_next;
        have_reg    <= have_next;
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
        if (slot_wr_en)
        begin
            slot_seq_reg[slot_wr_idx] <= slot_wr_seq;
            slot_tag_reg[slot_wr_idx] <= slot_wr_tag;
            slot_len_reg[slot_wr_idx] <= slot_wr_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_reg       <= sror_pkg::RST_START_SEQ;
            armed_reg     <= 1'b0;
            left_reg      <= '0;
            retry_reg     <= '0;
            lfsr_reg      <= sror_pkg::LFSR_SEED;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sror_pkg::SLOTS; i++)
            begin
                slot_used_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            armed_reg     <= armed_next;
            left_reg      <= left_next;
            retry_reg     <= retry_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            if (slot_wr_en)
            begin
                slot_used_reg[slot_wr_idx] <= 1'b1;
            end
            if (slot_clr_en)
            begin
                slot_used_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_delay_reg   <= sror_pkg::RST_GAP_DELAY;
            jitter_mask_reg <= sror_pkg::RST_JITTER_MASK;
            gap_retry_reg   <= sror_pkg::RST_GAP_RETRY;
            snap_wait_reg   <= sror_pkg::RST_SNAP_WAIT;
            retry_limit_reg <= sror_pkg::RST_RETRY_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                sror_pkg::CFG_START_SEQ:   ;
                sror_pkg::CFG_GAP_DELAY:   gap_delay_reg   <= cfg_data;
                sror_pkg::CFG_JITTER_MASK: jitter_mask_reg <= cfg_data[sror_pkg::MASK_W-1:0];
                sror_pkg::CFG_GAP_RETRY:   gap_retry_reg   <= cfg_data;
                sror_pkg::CFG_SNAP_WAIT:   snap_wait_reg   <= cfg_data;
                sror_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[sror_pkg::RETRY_W-1:0];
                default:                   ;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped outside idle");

    a_drain_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> slot_used_reg[idx_reg])
        else $error("draining an empty slot");

    a_snap_retry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SNAP) |-> (retry_reg == '0))
        else $error("retry count not cleared before snapshot");

    a_snap_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.kind == sror_pkg::KIND_SNAP)) |-> out_data_reg.last)
        else $error("snapshot request not marked last");

endmodule

>>> sv/sequence_reorder_gap_requester_top.sv
// Top level: sequence reorder buffer with gap and snapshot requests.
//
//  channel  dir  handshake        payload
//  item     in   valid/ready      opcode, seq, pkt_tag, pkt_len
//  result   out  valid/ready      kind, seq_out, to_seq, out_tag, out_len, last
//  cfg      in   cfg_we           cfg_idx, cfg_data
//
// A tick that expires the gap timer scans every slot, then issues a gap request, and a
// snapshot request once the retry limit is reached (neither with an empty buffer); an
// early packet with a full buffer scans every slot; an in-order packet drains successors.
// The back end serves one request at a time; slot scans step one slot per cycle.
// A two-entry input queue and a result register decouple both sides from stalls.
// Reset is asynchronous active low and clears all slots and control state.
module sequence_reorder_gap_requester_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    sror_item_if.sink                         item,
    sror_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [sror_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [sror_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic            q_valid;
    sror_pkg::item_t q_item;
    logic            q_pop;

    sror_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    sror_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

endmodule

>>> test/sequence_reorder_gap_requester_top_tb.sv
// Testbench: self-checking regression of the sequence reorder gap requester top level.
module sequence_reorder_gap_requester_top_tb;
    import sror_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam logic                 OP_PKT     = 1'b0;
    localparam logic                 OP_TICK    = 1'b1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sror_item_if   item_ch();
    sror_result_if res_ch();

    sequence_reorder_gap_requester_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (res_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // reorder model state
    logic [SEQ_W-1:0]   m_delay, m_retry_ms, m_snap_ms;
    logic [MASK_W-1:0]  m_mask;
    logic [RETRY_W-1:0] m_limit;
    logic               m_used [SLOTS];
    logic [SEQ_W-1:0]   m_seq  [SLOTS];
    logic [TAG_W-1:0]   m_tag  [SLOTS];
    logic [LEN_W-1:0]   m_len  [SLOTS];
    logic [SEQ_W-1:0]   m_next;
    logic               m_armed;
    logic [LEFT_W-1:0]  m_left;
    logic [RETRY_W-1:0] m_retries;
    logic [15:0]        m_lfsr;

    result_t pending_q[$];
    int      err_cnt;
    int      hold_cnt;
    int      wait_cnt;
    bit      took;
    bit      quiet;

    always #5 clk = ~clk;

    function automatic logic seq_behind(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

    function automatic bit slots_busy();
        for (int i = 0; i < SLOTS; i++)
            if (m_used[i])
                return 1;
        return 0;
    endfunction

    function automatic void arm_gap_timer();
        logic lsb;
        if (!m_armed && slots_busy())
        begin
            lsb    = m_lfsr[0];
            m_lfsr = m_lfsr >> 1;
            if (lsb)
                m_lfsr = m_lfsr ^ LFSR_TAPS;
            m_left    = {1'b0, m_delay} + LEFT_W'(m_lfsr[7:0] & m_mask);
            m_armed   = 1;
            m_retries = '0;
        end
    endfunction

    function automatic void push_result(logic [KIND_W-1:0] k, logic [SEQ_W-1:0] s,
                                        logic [SEQ_W-1:0] t, logic [TAG_W-1:0] tg,
                                        logic [LEN_W-1:0] ln);
        result_t r;
        r.kind = k; r.seq_out = s; r.to_seq = t; r.out_tag = tg; r.out_len = ln; r.last = 0;
        pending_q.push_back(r);
    endfunction

    function automatic void buffer_early(logic [SEQ_W-1:0] s, logic [TAG_W-1:0] tg,
                                         logic [LEN_W-1:0] ln);
        int far;
        far = 0;
        for (int i = 0; i < SLOTS; i++)
            if (m_used[i] && m_seq[i] == s)
                return;
        for (int i = 0; i < SLOTS; i++)
            if (!m_used[i])
            begin
                m_used[i] = 1; m_seq[i] = s; m_tag[i] = tg; m_len[i] = ln;
                return;
            end
        for (int i = 1; i < SLOTS; i++)
            if (m_seq[i] != m_seq[far] && !seq_behind(m_seq[i], m_seq[far]))
                far = i;
        if (seq_behind(s, m_seq[far]))
        begin
            m_seq[far] = s; m_tag[far] = tg; m_len[far] = ln;
        end
    endfunction

    // expected results of one accepted request
    function automatic void predict_request(logic op, logic [SEQ_W-1:0] s,
                                            logic [TAG_W-1:0] tg, logic [LEN_W-1:0] ln);
        int  n0;
        bit  found;
        bit  have;
        logic [SEQ_W-1:0] mn;
        n0 = pending_q.size();
        if (op == OP_PKT)
        begin
            if (seq_behind(s, m_next))
                return;
            if (s == m_next)
            begin
                push_result(KIND_DELIVER, s, '0, tg, ln);
                m_next++;
                do
                begin
                    found = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (!found && m_used[i] && m_seq[i] == m_next)
                        begin
                            found = 1;
                            m_used[i] = 0;
                            push_result(KIND_DELIVER, m_next, '0, m_tag[i], m_len[i]);
                            m_next++;
                        end
                end
                while (found);
                m_armed = 0;
                arm_gap_timer();
            end
            else
            begin
                buffer_early(s, tg, ln);
                arm_gap_timer();
            end
        end
        else
        begin
            if (!m_armed)
                return;
            if (m_left > 1)
            begin
                m_left--;
                return;
            end
            have = 0;
            mn   = '0;
            for (int i = 0; i < SLOTS; i++)
                if (m_used[i] && (!have || seq_behind(m_seq[i], mn)))
                begin
                    mn = m_seq[i];
                    have = 1;
                end
            if (!have)
            begin
                m_armed = 0;
                m_left  = '0;
                return;
            end
            push_result(KIND_GAP, m_next, mn - 1'b1, '0, '0);
            if (m_retries >= m_limit)
            begin
                push_result(KIND_SNAP, '0, '0, '0, '0);
                m_retries = '0;
                m_left    = {1'b0, m_snap_ms};
            end
            else
            begin
                m_retries++;
                m_left = {1'b0, m_retry_ms};
            end
        end
        if (pending_q.size() > n0)
            pending_q[$].last = 1;
    endfunction

    task automatic send_request(logic op, logic [SEQ_W-1:0] s, logic [TAG_W-1:0] tg,
                                logic [LEN_W-1:0] ln);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_ch.valid = 0;
            repeat (gap) @(negedge clk);
        end
        item_ch.opcode  = op;
        item_ch.seq     = s;
        item_ch.pkt_tag = tg;
        item_ch.pkt_len = ln;
        item_ch.valid   = 1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predict_request(op, s, tg, ln);
        @(negedge clk);
    endtask

    task automatic send_packet(logic [SEQ_W-1:0] s);
        send_request(OP_PKT, s, $urandom, LEN_W'($urandom_range(0, 250)));
    endtask

    task automatic send_tick();
        send_request(OP_TICK, SEQ_W'($urandom), $urandom, LEN_W'($urandom));
    endtask

    task automatic drain_and_settle();
        item_ch.valid = 0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 0;
        case (idx)
            CFG_START_SEQ:   m_next     = data;
            CFG_GAP_DELAY:   m_delay    = data;
            CFG_JITTER_MASK: m_mask     = data[MASK_W-1:0];
            CFG_GAP_RETRY:   m_retry_ms = data;
            CFG_SNAP_WAIT:   m_snap_ms  = data;
            CFG_RETRY_LIMIT: m_limit    = data[RETRY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [15:0] st, logic [15:0] dly, logic [7:0] msk,
                                 logic [15:0] rty, logic [15:0] snp, logic [3:0] lim);
        drain_and_settle();
        write_reg(CFG_START_SEQ, st);
        write_reg(CFG_GAP_DELAY, dly);
        write_reg(CFG_JITTER_MASK, {8'h00, msk});
        write_reg(CFG_GAP_RETRY, rty);
        write_reg(CFG_SNAP_WAIT, snp);
        write_reg(CFG_RETRY_LIMIT, {12'h000, lim});
    endtask

    // mostly in-order or slightly early packets, some stale, some far off, many ticks
    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_tick();
        else if (pick < 62)
            send_packet(m_next);
        else if (pick < 88)
            send_packet(m_next + SEQ_W'($urandom_range(1, 12)));
        else if (pick < 95)
            send_packet(m_next - SEQ_W'($urandom_range(1, 20)));
        else
            send_packet(SEQ_W'($urandom));
    endtask

    task automatic test_directed();
        load_settings(16'hFFFE, 16'd0, 8'd0, 16'd1, 16'd2, 4'd0);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        send_request(OP_PKT, 16'h0001, 32'hFFFF_FFFF, 8'd250);
        send_request(OP_PKT, 16'h0000, 32'h0000_0000, 8'd0);
        send_packet(16'h0000);
        send_tick();
        send_tick();
        send_tick();
        send_packet(16'hFFFE);
        send_packet(16'hFFFE);
        send_packet(16'hFFFF);
        send_packet(16'h8002);
        for (int i = 10; i < 18; i++)
            send_packet(16'(i));
        send_packet(16'd12);
        send_packet(16'd5);
        send_packet(16'd30);
        send_tick();
        send_tick();
        for (int i = 2; i < 10; i++)
            send_packet(16'(i));
    endtask

    task automatic test_settings_sweep();
        load_settings(16'h0000, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
        repeat (25) random_request();
        load_settings(16'($urandom), 16'd1, 8'h03, 16'd0, 16'd0, 4'hF);
        repeat (45) random_request();
        for (int p = 0; p < 4; p++)
        begin
            load_settings(16'($urandom), 16'($urandom_range(0, 4)),
                          8'($urandom_range(0, 7)), 16'($urandom_range(0, 4)),
                          16'($urandom_range(0, 5)), 4'($urandom_range(0, 15)));
            quiet = (p == 1);
            repeat (25) random_request();
        end
        quiet = 0;
        load_settings(16'h7FFF, 16'd2, 8'hFF, 16'd3, 16'd1, 4'd1);
        repeat (30) random_request();
    endtask

    task automatic test_backpressure();
        load_settings(16'($urandom), 16'd0, 8'd0, 16'd0, 16'd0, 4'd0);
        hold_cnt = 300;
        repeat (30) random_request();
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.kind = res_ch.kind; got.seq_out = res_ch.seq_out; got.to_seq = res_ch.to_seq;
            got.out_tag = res_ch.out_tag; got.out_len = res_ch.out_len; got.last = res_ch.last;
            took = 1;
            if (pending_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.kind != want.kind || got.seq_out != want.seq_out ||
                    got.to_seq != want.to_seq || got.out_tag != want.out_tag ||
                    got.out_len != want.out_len || got.last != want.last)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (took)
        begin
            took = 0;
            wait_cnt = quiet ? 0 : $urandom_range(0, 8);
        end
        if (hold_cnt > 0)
        begin
            res_ch.ready = 0;
            hold_cnt--;
        end
        else if (wait_cnt > 0)
        begin
            res_ch.ready = 0;
            wait_cnt--;
        end
        else
            res_ch.ready = 1;
    end

    initial
    begin
        #20_000_000;
        $display("sequence_reorder_gap_requester_top regression: fail");
        $finish;
    end

    initial
    begin
        clk = 0; rst_n = 0;
        cfg_we = 0; cfg_idx = '0; cfg_data = '0;
        item_ch.valid = 0; item_ch.opcode = 0; item_ch.seq = '0;
        item_ch.pkt_tag = '0; item_ch.pkt_len = '0;
        res_ch.ready = 0;
        err_cnt = 0; hold_cnt = 0; wait_cnt = 0; took = 0; quiet = 0;
        m_delay = RST_GAP_DELAY; m_mask = RST_JITTER_MASK;
        m_retry_ms = RST_GAP_RETRY; m_snap_ms = RST_SNAP_WAIT; m_limit = RST_RETRY_LIMIT;
        for (int i = 0; i < SLOTS; i++)
        begin
            m_used[i] = 0; m_seq[i] = '0; m_tag[i] = '0; m_len[i] = '0;
        end
        m_next = RST_START_SEQ; m_armed = 0; m_left = '0; m_retries = '0; m_lfsr = LFSR_SEED;
        repeat (9) @(negedge clk);
        rst_n = 1;
        repeat (4) @(negedge clk);
        send_packet(16'd0);
        send_packet(16'd2);
        send_tick();
        test_directed();
        test_settings_sweep();
        test_backpressure();
        drain_and_settle();
        if (err_cnt == 0 && pending_q.size() == 0)
            $display("sequence_reorder_gap_requester_top regression: pass");
        else
            $display("sequence_reorder_gap_requester_top regression: fail");
        $finish;
    end
endmodule

>>> files.f
sv/sror_pkg.sv
sv/sror_item_if.sv
sv/sror_result_if.sv
sv/sror_front.sv
sv/sror_back.sv
sv/sequence_reorder_gap_requester_top.sv
test/sequence_reorder_gap_requester_top_tb.sv
